// File: hw/rtl/dcrc_pkg.sv
// shared constants and crc byte-update functions for the dual crc engine
// no dependencies
`timescale 1ns / 1ps

package dcrc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_CRC_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED     = 1'd1;

  localparam logic MODE_CRC8  = 1'b0;
  localparam logic MODE_CRC16 = 1'b1;

  localparam logic [CRC_W-1:0]  POLY16   = 16'h1021;
  localparam logic [BYTE_W-1:0] POLY8    = 8'h8C;
  localparam logic [CRC_W-1:0]  INV_MASK = 16'hFFFF;

  // msb-first ccitt update, byte folded into the top byte
  function automatic logic [CRC_W-1:0] fold16(input logic [CRC_W-1:0] acc_in,
                                              input logic [BYTE_W-1:0] byte_in);
    logic [CRC_W-1:0] acc;
    acc = acc_in ^ {byte_in, 8'h00};
    for (int n = 0; n < BYTE_W; n++) begin
      if (acc[CRC_W-1]) begin
        acc = {acc[CRC_W-2:0], 1'b0} ^ POLY16;
      end else begin
        acc = {acc[CRC_W-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // lsb-first reflected 0x8c update
  function automatic logic [BYTE_W-1:0] fold8(input logic [BYTE_W-1:0] acc_in,
                                              input logic [BYTE_W-1:0] byte_in);
    logic [BYTE_W-1:0] acc;
    acc = acc_in ^ byte_in;
    for (int n = 0; n < BYTE_W; n++) begin
      if (acc[0]) begin
        acc = {1'b0, acc[BYTE_W-1:1]} ^ POLY8;
      end else begin
        acc = {1'b0, acc[BYTE_W-1:1]};
      end
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/dual_crc8_crc16_engine_top.sv
// top level of the dual crc-8 / crc-16 streaming engine
// depends on dcrc_pkg for constants and the byte-update functions
`timescale 1ns / 1ps

// Takes one message byte per cycle while out_tready does not stall the result
// stream and returns one running CRC per byte. The byte is captured in the
// input register when taken; its CRC is captured in the result register once
// that register is free. The whole eight-bit update, CRC-16 CCITT (0x1021,
// msb first) or reflected CRC-8 (0x8C, lsb first) as selected by crc_mode,
// is done combinationally between those two registers, which sets the rate
// of one byte per clock. The first byte of each message starts from seed; on
// the byte with tlast set the result carries tuser = 1 and, in CRC-16 mode,
// the inverted CRC, and the next byte begins a new message. In CRC-8 mode
// the upper byte of the result is zero. Registers are to be written by the
// user through cfg_we / cfg_addr / cfg_wdata (0: crc_mode, 1: seed) while no
// request is in flight; the block itself does not enforce this.
module dual_crc8_crc16_engine_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dcrc_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] data_byte
  input  logic                               in_tlast,   // last_byte
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dcrc_pkg::CRC_W-1:0]         out_tdata,  // [15:0] crc_value
  output logic                               out_tuser,  // final_res
  // configuration
  input  logic                               cfg_we,
  input  logic [dcrc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [dcrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                          crc_mode_r;
  logic [dcrc_pkg::CRC_W-1:0]    seed_r;
  logic [dcrc_pkg::CRC_W-1:0]    running_crc_r;
  logic [dcrc_pkg::CRC_W-1:0]    running_crc_nxt;
  logic                          msg_start_r;

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic [dcrc_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                          s1_last_r;

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [dcrc_pkg::CRC_W-1:0]    out_crc_r;
  logic                          out_final_r;

  logic                          adv;
  logic                          in_acc;
  logic [dcrc_pkg::CRC_W-1:0]    acc_base;
  logic [dcrc_pkg::CRC_W-1:0]    shown;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_crc_r;
  assign out_tuser  = out_final_r;

  // crc update
  always_comb begin
    acc_base = msg_start_r ? seed_r : running_crc_r;
    if (crc_mode_r == dcrc_pkg::MODE_CRC16) begin
      running_crc_nxt = dcrc_pkg::fold16(acc_base, s1_byte_r);
    end else begin
      running_crc_nxt = {8'h00, dcrc_pkg::fold8(acc_base[7:0], s1_byte_r)};
    end
    if (s1_last_r && crc_mode_r == dcrc_pkg::MODE_CRC16) begin
      shown = running_crc_nxt ^ dcrc_pkg::INV_MASK;
    end else begin
      shown = running_crc_nxt;
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_mode_r <= dcrc_pkg::MODE_CRC16;
      seed_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dcrc_pkg::REG_CRC_MODE: crc_mode_r <= cfg_wdata[0];
        dcrc_pkg::REG_SEED:     seed_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control and crc state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      running_crc_r <= '0;
      msg_start_r   <= 1'b1;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        running_crc_r <= running_crc_nxt;
        msg_start_r   <= s1_last_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (adv) begin
      out_crc_r   <= shown;
      out_final_r <= s1_last_r;
    end
  end

`ifndef SYNTHESIS
  a_msg_start_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> msg_start_r == $past(s1_last_r))
    else $error("message start flag does not follow last byte");

  a_crc8_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && crc_mode_r == dcrc_pkg::MODE_CRC8) |=> out_tdata[15:8] == 8'h00)
    else $error("crc-8 result has nonzero upper byte");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(running_crc_r) && $stable(msg_start_r))
    else $error("crc state changed without a request");

  a_final_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tuser == $past(s1_last_r) && out_tvalid)
    else $error("result final flag does not match last byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");
`endif

endmodule
